// ===== hw/rtl/all_pairs_shortest_path_unit_assert.svh =====
// Assertion macros for the all-pairs shortest path unit.
`ifndef ALL_PAIRS_SHORTEST_PATH_UNIT_ASSERT_SVH
`define ALL_PAIRS_SHORTEST_PATH_UNIT_ASSERT_SVH

`ifndef SYNTH
`define APSP_ASSERT_ALWAYS(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define APSP_ASSERT_NEXT(lbl, clk, rst, cause, effect) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cause) |=> (effect)) \
      else $error("assertion failed");
`else
`define APSP_ASSERT_ALWAYS(lbl, clk, rst, prop)
`define APSP_ASSERT_NEXT(lbl, clk, rst, cause, effect)
`endif

`endif

// ===== hw/rtl/apsp_pkg.sv =====
package apsp_pkg;

   localparam int ACTIVE_BITS = 5;
   localparam int DIST_BITS   = 16;

   localparam logic [ACTIVE_BITS-1:0] ACTIVE_RESET = 5'd16;
   localparam logic [DIST_BITS-1:0]   DIST_INF     = 16'hFFFF;

   localparam logic [1:0] MODE_LOAD  = 2'd0;
   localparam logic [1:0] MODE_RUN   = 2'd1;
   localparam logic [1:0] MODE_QUERY = 2'd2;
   localparam logic [1:0] MODE_CLEAR = 2'd3;

   typedef struct packed {
      logic [1:0]  mode;
      logic [3:0]  from_vertex;
      logic [3:0]  to_vertex;
      logic [15:0] edge_weight;
   } req_type;

   typedef struct packed {
      logic [15:0] distance;
      logic        reachable;
   } rsp_type;

endpackage

// ===== hw/rtl/all_pairs_shortest_path_unit.sv =====
// Load: written at accept, then S_DONE. Query: read at accept, S_QCAP, S_DONE.
// Clear: writes INF to all (MAX_VERTICES up to a power of two, min 2)^2 entries.
// Run with n active vertices: speed is set by the single read port of the
// distance store, which is read twice for each relaxation.
// One item at a time. Reset is synchronous; afterwards the store is filled with
// infinity one entry per cycle (the same sweep as a clear) before req_ready rises.
module all_pairs_shortest_path_unit
   import apsp_pkg::*;
#(
   parameter int MAX_VERTICES = 16,
   parameter int WEIGHT_BITS  = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   input  logic                   csr_wr_en,
   input  logic [ACTIVE_BITS-1:0] csr_wr_data
);

   `include "all_pairs_shortest_path_unit_assert.svh"

   localparam int VB    = (MAX_VERTICES > 2) ? $clog2(MAX_VERTICES) : 1;
   localparam int AB    = 2 * VB;
   localparam int DEPTH = 1 << AB;
   localparam logic [WEIGHT_BITS-1:0] INF = {WEIGHT_BITS{1'b1}};

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_INIT  = 4'd1;
   localparam logic [3:0] S_CLEAR = 4'd2;
   localparam logic [3:0] S_LREQ  = 4'd3;
   localparam logic [3:0] S_LCAP  = 4'd4;
   localparam logic [3:0] S_RREQ  = 4'd5;
   localparam logic [3:0] S_CREQ  = 4'd6;
   localparam logic [3:0] S_UPD   = 4'd7;
   localparam logic [3:0] S_QCAP  = 4'd8;
   localparam logic [3:0] S_DONE  = 4'd9;

   logic [3:0]             state_ff, state_in;
   logic [ACTIVE_BITS-1:0] active_ff, active_in;
   logic [AB-1:0]          sweep_ff, sweep_in;
   logic [VB-1:0]          k_ff, k_in;
   logic [VB-1:0]          i_ff, i_in;
   logic [VB-1:0]          j_ff, j_in;
   logic [VB-1:0]          last_ff, last_in;
   logic [WEIGHT_BITS-1:0] left_ff, left_in;
   logic [WEIGHT_BITS-1:0] right_ff, right_in;
   logic                   range_ff, range_in;
   rsp_type                res_ff, res_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   logic                   wr_en;
   logic [AB-1:0]          wr_addr;
   logic [WEIGHT_BITS-1:0] wr_data;
   logic [AB-1:0]          rd_addr;
   logic [WEIGHT_BITS-1:0] rd_data;
   logic                   improve;
   logic [WEIGHT_BITS-1:0] sum;

   logic                   req_in_range;
   logic [WEIGHT_BITS-1:0] req_weight;
   logic [AB-1:0]          req_addr;
   logic [31:0]            rd_wide;

   apsp_ram #(
      .WIDTH (WEIGHT_BITS),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   apsp_relax #(
      .WEIGHT_BITS (WEIGHT_BITS)
   ) u_relax (
      .left    (left_ff),
      .right   (right_ff),
      .current (rd_data),
      .improve (improve),
      .sum     (sum)
   );

   assign req_ready    = (state_ff == S_IDLE);
   assign req_in_range = (int'(req_data.from_vertex) < MAX_VERTICES) &&
                         (int'(req_data.to_vertex) < MAX_VERTICES);
   assign req_weight   = WEIGHT_BITS'(req_data.edge_weight);
   assign req_addr     = {VB'(req_data.from_vertex), VB'(req_data.to_vertex)};
   assign rd_wide      = 32'(rd_data);

   always_comb begin
      state_in     = state_ff;
      active_in    = active_ff;
      sweep_in     = sweep_ff;
      k_in         = k_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      last_in      = last_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      range_in     = range_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = req_addr;
      wr_data      = req_weight;
      rd_addr      = req_addr;

      if (csr_wr_en) begin
         active_in = csr_wr_data;
      end
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               res_in   = '0;
               range_in = req_in_range;
               unique case (req_data.mode)
                  MODE_LOAD: begin
                     wr_en    = req_in_range && (req_weight != INF);
                     state_in = S_DONE;
                  end
                  MODE_RUN: begin
                     k_in = '0;
                     i_in = '0;
                     if (active_ff == '0) begin
                        state_in = S_DONE;
                     end else begin
                        if (int'(active_ff) > MAX_VERTICES) begin
                           last_in = VB'(MAX_VERTICES - 1);
                        end else begin
                           last_in = VB'(active_ff - 1'b1);
                        end
                        state_in = S_LREQ;
                     end
                  end
                  MODE_QUERY: begin
                     state_in = S_QCAP;
                  end
                  MODE_CLEAR: begin
                     sweep_in = '0;
                     state_in = S_CLEAR;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_INIT, S_CLEAR: begin
            wr_en    = 1'b1;
            wr_addr  = sweep_ff;
            wr_data  = INF;
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == '1) begin
               state_in = (state_ff == S_INIT) ? S_IDLE : S_DONE;
            end
         end
         S_LREQ: begin
            rd_addr  = {i_ff, k_ff};
            state_in = S_LCAP;
         end
         S_LCAP: begin
            left_in = rd_data;
            j_in    = '0;
            if (rd_data == INF) begin
               if (i_ff == last_ff) begin
                  i_in = '0;
                  k_in = k_ff + 1'b1;
                  state_in = (k_ff == last_ff) ? S_DONE : S_LREQ;
               end else begin
                  i_in     = i_ff + 1'b1;
                  state_in = S_LREQ;
               end
            end else begin
               state_in = S_RREQ;
            end
         end
         S_RREQ: begin
            rd_addr  = {k_ff, j_ff};
            state_in = S_CREQ;
         end
         S_CREQ: begin
            right_in = rd_data;
            rd_addr  = {i_ff, j_ff};
            state_in = S_UPD;
         end
         S_UPD: begin
            wr_en   = improve;
            wr_addr = {i_ff, j_ff};
            wr_data = sum;
            if (j_ff == last_ff) begin
               j_in = '0;
               if (i_ff == last_ff) begin
                  i_in = '0;
                  k_in = k_ff + 1'b1;
                  state_in = (k_ff == last_ff) ? S_DONE : S_LREQ;
               end else begin
                  i_in     = i_ff + 1'b1;
                  state_in = S_LREQ;
               end
            end else begin
               j_in     = j_ff + 1'b1;
               state_in = S_RREQ;
            end
         end
         S_QCAP: begin
            if (range_ff && (rd_data != INF)) begin
               res_in.distance  = (rd_wide > 32'h0000_FFFF) ? DIST_INF : rd_wide[15:0];
               res_in.reachable = 1'b1;
            end else begin
               res_in.distance  = DIST_INF;
               res_in.reachable = 1'b0;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         active_ff    <= ACTIVE_RESET;
         sweep_ff     <= '0;
         k_ff         <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         last_ff      <= '0;
         range_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         sweep_ff     <= sweep_in;
         k_ff         <= k_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         last_ff      <= last_in;
         range_ff     <= range_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff     <= left_in;
      right_ff    <= right_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `APSP_ASSERT_NEXT(a_accept_leaves_idle, clock, reset, req_valid && req_ready, state_ff != S_IDLE)
   `APSP_ASSERT_NEXT(a_rsp_only_from_done, clock, reset, !rsp_valid_ff && (state_ff != S_DONE), !rsp_valid_ff)
   `APSP_ASSERT_ALWAYS(a_unreachable_value, clock, reset, !rsp_valid_ff || rsp_data_ff.reachable || (rsp_data_ff.distance == DIST_INF) || (rsp_data_ff.distance == '0))
   `APSP_ASSERT_ALWAYS(a_index_bound, clock, reset, (state_ff != S_UPD) || ((i_ff <= last_ff) && (j_ff <= last_ff) && (k_ff <= last_ff)))

endmodule

// ===== hw/rtl/apsp_ram.sv =====
module apsp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/apsp_relax.sv =====
module apsp_relax #(
   parameter int WEIGHT_BITS = 16
) (
   input  logic [WEIGHT_BITS-1:0] left,
   input  logic [WEIGHT_BITS-1:0] right,
   input  logic [WEIGHT_BITS-1:0] current,
   output logic                   improve,
   output logic [WEIGHT_BITS-1:0] sum
);

   localparam logic [WEIGHT_BITS-1:0] INF = {WEIGHT_BITS{1'b1}};

   logic [WEIGHT_BITS:0] wide_sum;

   // A path through an infinite leg never improves; the sum is compared
   // with one extra bit so that it cannot wrap.
   assign wide_sum = {1'b0, left} + {1'b0, right};
   assign improve  = (left != INF) && (right != INF) && (wide_sum < {1'b0, current});
   assign sum      = wide_sum[WEIGHT_BITS-1:0];

endmodule
